// ----- src/bpc_pkg.sv -----
`default_nettype none

package bpc_pkg;

   // Configuration port geometry
   localparam int unsigned CsrIndexWidth = 2;
   localparam int unsigned CsrDataWidth  = 16;

   // Field widths
   localparam int unsigned TimeWidth = 32;

   // Register reset values in ms
   localparam logic [CsrDataWidth-1:0] LongHoldReset     = 16'd2000;
   localparam logic [CsrDataWidth-1:0] ShortMaxReset     = 16'd500;
   localparam logic [CsrDataWidth-1:0] DoubleWindowReset = 16'd400;

   // Register indexes
   typedef enum logic [CsrIndexWidth-1:0] {
      CSR_LONG_HOLD     = 2'd0,
      CSR_SHORT_MAX     = 2'd1,
      CSR_DOUBLE_WINDOW = 2'd2
   } csr_index_type;

   // Timing thresholds as seen by the classifier
   typedef struct packed {
      logic [CsrDataWidth-1:0] long_hold_ms;
      logic [CsrDataWidth-1:0] short_max_ms;
      logic [CsrDataWidth-1:0] double_window_ms;
   } bpc_cfg_type;

   // Press tracking state carried from one poll to the next
   typedef struct packed {
      logic                 press_active;
      logic [TimeWidth-1:0] press_start_time;
      logic [TimeWidth-1:0] last_short_time;
   } bpc_state_type;

   // One poll after it has been registered
   typedef struct packed {
      logic [TimeWidth-1:0] now_ms;
      logic                 button_down;
      logic                 battery_present;
   } bpc_poll_type;

   // Event flags of one poll
   typedef struct packed {
      logic shutdown_request;
      logic short_press;
      logic double_press;
   } bpc_flags_type;

endpackage

`default_nettype wire

// ----- src/bpc_req_if.sv -----
`default_nettype none

interface bpc_req_if
   import bpc_pkg::*;
();
   logic                 valid;
   logic                 ready;
   logic [TimeWidth-1:0] now_ms;
   logic                 button_down;
   logic                 battery_present;

   modport source (output valid, output now_ms, output button_down,
                   output battery_present, input ready);
   modport sink   (input valid, input now_ms, input button_down,
                   input battery_present, output ready);
endinterface

`default_nettype wire

// ----- src/bpc_rsp_if.sv -----
`default_nettype none

interface bpc_rsp_if;
   logic valid;
   logic ready;
   logic shutdown_request;
   logic short_press;
   logic double_press;

   modport source (output valid, output shutdown_request, output short_press,
                   output double_press, input ready);
   modport sink   (input valid, input shutdown_request, input short_press,
                   input double_press, output ready);
endinterface

`default_nettype wire

// ----- src/bpc_csr.sv -----
`default_nettype none

module bpc_csr
   import bpc_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     csr_wr_en,
   input  wire logic [CsrIndexWidth-1:0] csr_index,
   input  wire logic [CsrDataWidth-1:0]  csr_wdata,
   output bpc_cfg_type                   cfg
);

   bpc_cfg_type cfg_ff;
   bpc_cfg_type cfg_in;

   // Decode the write; unknown indexes are dropped
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_LONG_HOLD:     cfg_in.long_hold_ms     = csr_wdata;
            CSR_SHORT_MAX:     cfg_in.short_max_ms     = csr_wdata;
            CSR_DOUBLE_WINDOW: cfg_in.double_window_ms = csr_wdata;
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.long_hold_ms     <= LongHoldReset;
         cfg_ff.short_max_ms     <= ShortMaxReset;
         cfg_ff.double_window_ms <= DoubleWindowReset;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

// ----- src/bpc_eval.sv -----
`default_nettype none

module bpc_eval
   import bpc_pkg::*;
(
   input  bpc_poll_type  poll,
   input  bpc_cfg_type   cfg,
   input  bpc_state_type state_cur,
   output bpc_state_type state_nxt,
   output bpc_flags_type flags
);

   logic [TimeWidth-1:0] held;
   logic [TimeWidth-1:0] gap;
   logic                 long_reached;
   logic                 is_short;
   logic                 in_window;

   // Wrapping elapsed times since press start and since the last short press
   assign held = poll.now_ms - state_cur.press_start_time;
   assign gap  = poll.now_ms - state_cur.last_short_time;

   // Long hold only on a non-negative elapsed time
   assign long_reached = !held[TimeWidth-1] &&
                         (held >= {{(TimeWidth-CsrDataWidth){1'b0}}, cfg.long_hold_ms});
   assign is_short     = held < {{(TimeWidth-CsrDataWidth){1'b0}}, cfg.short_max_ms};
   // A negative gap counts as inside the window
   assign in_window    = gap[TimeWidth-1] ||
                         (gap <= {{(TimeWidth-CsrDataWidth){1'b0}}, cfg.double_window_ms});

   // Classify the poll and work out the next press state
   always_comb begin
      state_nxt = state_cur;
      flags     = '0;
      if (poll.battery_present) begin
         if (poll.button_down && !state_cur.press_active) begin
            state_nxt.press_start_time = poll.now_ms;
            state_nxt.press_active     = 1'b1;
         end else if (poll.button_down && state_cur.press_active) begin
            if (long_reached) begin
               state_nxt.press_active = 1'b0;
               flags.shutdown_request = 1'b1;
            end
         end else if (!poll.button_down && state_cur.press_active) begin
            state_nxt.press_active = 1'b0;
            if (is_short) begin
               if ((state_cur.last_short_time != '0) && in_window) begin
                  state_nxt.last_short_time = '0;
                  flags.double_press        = 1'b1;
               end else begin
                  state_nxt.last_short_time = poll.now_ms;
                  flags.short_press         = 1'b1;
               end
            end
         end
      end
   end

endmodule

`default_nettype wire

// ----- src/button_press_classifier_core.sv -----
// Button press classifier. Each poll item (timestamp, button level, battery
// flag) yields exactly one result item with shutdown, short-press and
// double-press flags. The block takes one item per clock cycle while the
// result side is not stalled; an item is captured in an input register,
// classified by a single pass of compare and subtract logic against the
// press state, and lands in a result register, from which the result item
// is presented. The press state is updated in the same cycle the result is
// registered, so consecutive items see each other's effect. A stalled
// result side holds both registers and drops req_chan.ready once the
// input register is full. Thresholds are written through the csr_ port and
// should only change while the block is idle.
`default_nettype none

module button_press_classifier_core
   import bpc_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   bpc_req_if.sink                       req_chan,
   bpc_rsp_if.source                     rsp_chan,
   input  wire logic                     csr_wr_en,
   input  wire logic [CsrIndexWidth-1:0] csr_index,
   input  wire logic [CsrDataWidth-1:0]  csr_wdata
);

   bpc_cfg_type   cfg;
   bpc_state_type state_ff;
   bpc_state_type state_in;
   bpc_poll_type  poll_ff;
   logic          poll_valid_ff;
   bpc_flags_type flags_in;
   bpc_flags_type flags_ff;
   logic          rsp_valid_ff;
   logic          advance;
   logic          take_req;

   bpc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   bpc_eval u_eval (
      .poll      (poll_ff),
      .cfg       (cfg),
      .state_cur (state_ff),
      .state_nxt (state_in),
      .flags     (flags_in)
   );

   // Advance the result stage when it is empty or being taken
   assign advance  = !rsp_valid_ff || rsp_chan.ready;
   assign take_req = req_chan.valid && req_chan.ready;
   assign req_chan.ready = !poll_valid_ff || advance;

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         poll_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         poll_valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (take_req) begin
         poll_ff.now_ms          <= req_chan.now_ms;
         poll_ff.button_down     <= req_chan.button_down;
         poll_ff.battery_present <= req_chan.battery_present;
      end
   end

   // Commit press state together with the result
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else if (poll_valid_ff && advance) begin
         state_ff <= state_in;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= poll_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (poll_valid_ff && advance) begin
         flags_ff <= flags_in;
      end
   end

   assign rsp_chan.valid            = rsp_valid_ff;
   assign rsp_chan.shutdown_request = flags_ff.shutdown_request;
   assign rsp_chan.short_press      = flags_ff.short_press;
   assign rsp_chan.double_press     = flags_ff.double_press;

endmodule

`default_nettype wire

// ----- src/bpc_checker.sv -----
`default_nettype none

module bpc_checker (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_ready,
   input wire logic rsp_valid,
   input wire logic rsp_ready,
   input wire logic shutdown_request,
   input wire logic short_press,
   input wire logic double_press
);

   // No result item straight after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // A poll reports at most one event
   a_one_event: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ($countones({shutdown_request, short_press, double_press}) <= 1))
      else $error("more than one event flag in a result item");

   // Input side only stalls behind a stalled result
   a_ready_stall: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (rsp_valid && !rsp_ready))
      else $error("input stalled without a stalled result");

   // Stalled result item holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(shutdown_request) &&
                                     $stable(short_press) && $stable(double_press)))
      else $error("stalled result item changed");

endmodule

bind button_press_classifier_core bpc_checker u_bpc_checker (
   .clock            (clock),
   .reset            (reset),
   .req_ready        (req_chan.ready),
   .rsp_valid        (rsp_chan.valid),
   .rsp_ready        (rsp_chan.ready),
   .shutdown_request (rsp_chan.shutdown_request),
   .short_press      (rsp_chan.short_press),
   .double_press     (rsp_chan.double_press)
);

`default_nettype wire
